### src/i2cds_pkg.sv
// shared constants for the i2c clock divisor search
`timescale 1ns / 1ps

package i2cds_pkg;

    // datapath width of the shared divider
    localparam int C_DIV_W = 32;

    // reference clock after reset
    localparam logic [31:0] C_REF_RESET = 32'd111111115;

    // fixed prescale of the serial clock generator
    localparam logic [4:0] C_FIXED_DIV = 5'd22;

    // target clamping limits
    localparam logic [23:0] C_CLAMP_HIGH   = 24'd384600;
    localparam logic [23:0] C_CLAMP_MID_HI = 24'd100000;
    localparam logic [23:0] C_CLAMP_MID_LO = 24'd90000;

    // search limits
    localparam logic [5:0]  C_B_LAST = 6'd63;
    localparam logic [31:0] C_A_MAX  = 32'd3;

    // divisor fields of the control word
    localparam logic [31:0] C_MASK_A = 32'h0000C000;
    localparam logic [31:0] C_MASK_B = 32'h00003F00;

endpackage

### src/i2cds_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module i2cds_div
    import i2cds_pkg::*;
#(
    parameter int W = C_DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] C_LAST = CW'(W - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [W:0]    trial;

    // one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quo[W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == C_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### src/i2c_clock_divisor_search_unit.sv
// top level of the i2c clock divisor search unit
`timescale 1ns / 1ps

// Searches the two-stage serial clock divisor pair (a, b) for which
// ref / (22 * (a+1) * (b+1)) comes closest to the requested clock, and returns
// a, b and the control word with bits 15:14 = a and 13:8 = b. All arithmetic
// runs through one 32-bit restoring divider. The search tries one or two
// quotient candidates t and, for each, every b, dividing once more for each
// (t, b) point whose first-stage divisor fits (a <= 3); a zero target and a
// target too high for the reference skip the search. The input side is ready
// only while the sequencer is idle; a finished item waits in the output
// register, so the next item may enter before it is taken. The reference
// clock register resets to 111111115 Hz; the user must write it only while
// the unit is idle, which the unit itself does not enforce.

module i2c_clock_divisor_search_unit
    import i2cds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: reference clock in Hz
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // target_hz[23:0], control_in[55:24]
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // div_a[1:0], div_b[7:2], control_out[39:8]
    output logic [0:0]  o_m_tuser    // out_of_range[0]
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_W_TEMP = 3'd1;
    localparam logic [2:0] S_W_REM  = 3'd2;
    localparam logic [2:0] S_W_Q    = 3'd3;
    localparam logic [2:0] S_W_ACT  = 3'd4;
    localparam logic [2:0] S_NEXT_B = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_ref, n_ref;
    logic [31:0] r_ctrl, n_ctrl;
    logic [18:0] r_clamped, n_clamped;
    logic [31:0] r_temp, n_temp;
    logic [31:0] r_t, n_t;
    logic        r_inc, n_inc;
    logic        r_second, n_second;
    logic [5:0]  r_b, n_b;
    logic [1:0]  r_a, n_a;
    logic [31:0] r_last_err, n_last_err;
    logic [1:0]  r_cand_a, n_cand_a;
    logic [5:0]  r_cand_b, n_cand_b;
    logic [31:0] r_best_err, n_best_err;
    logic [1:0]  r_best_a, n_best_a;
    logic [5:0]  r_best_b, n_best_b;
    logic        r_oor, n_oor;
    logic        r_div_start, n_div_start;
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_dvs, n_dvs;
    logic        r_m_valid, n_m_valid;
    logic [39:0] r_m_data, n_m_data;
    logic        r_m_user, n_m_user;

    logic        div_busy, div_done;
    logic [31:0] div_quo, div_rem;

    logic        s_accept;
    logic [23:0] in_target;
    logic [31:0] in_ctrl;
    logic [23:0] clamp_hi;
    logic [18:0] clamp_val;
    logic [31:0] q_adj;
    logic [9:0]  ab_prod;
    logic [12:0] act_div;
    logic [31:0] act_err;
    logic [31:0] ctrl_new;

    // the one shared divider
    i2cds_div #(
        .W (C_DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_dvd),
        .i_divisor   (r_dvs),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign in_target = i_s_tdata[23:0];
    assign in_ctrl   = i_s_tdata[55:24];

    // clamp the incoming target
    assign clamp_hi  = (in_target > C_CLAMP_HIGH) ? C_CLAMP_HIGH : in_target;
    assign clamp_val = (clamp_hi <= C_CLAMP_MID_HI && clamp_hi > C_CLAMP_MID_LO)
                     ? C_CLAMP_MID_LO[18:0] : clamp_hi[18:0];

    // first-stage divisor from t / (b+1), and the divisor for the actual clock
    assign q_adj   = (div_quo == 32'd0) ? 32'd0 : div_quo - 32'd1;
    assign ab_prod = 10'({1'b0, q_adj[1:0]} + 3'd1) * 10'({1'b0, r_b} + 7'd1);
    assign act_div = {3'd0, ab_prod} * {8'd0, C_FIXED_DIV};

    // distance of the actual clock from the clamped target
    assign act_err = (div_quo > {13'd0, r_clamped}) ? div_quo - {13'd0, r_clamped}
                                                   : {13'd0, r_clamped} - div_quo;

    // control word with the chosen divisors inserted
    assign ctrl_new = (r_ctrl & ~(C_MASK_A | C_MASK_B))
                    | {16'd0, r_best_a, r_best_b, 8'd0};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ref       = r_ref;
        n_ctrl      = r_ctrl;
        n_clamped   = r_clamped;
        n_temp      = r_temp;
        n_t         = r_t;
        n_inc       = r_inc;
        n_second    = r_second;
        n_b         = r_b;
        n_a         = r_a;
        n_last_err  = r_last_err;
        n_cand_a    = r_cand_a;
        n_cand_b    = r_cand_b;
        n_best_err  = r_best_err;
        n_best_a    = r_best_a;
        n_best_b    = r_best_b;
        n_oor       = r_oor;
        n_div_start = 1'b0;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_ref = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_ctrl    = in_ctrl;
                    n_clamped = clamp_val;
                    if (in_target == 24'd0) begin
                        n_oor   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_oor       = 1'b0;
                        n_dvd       = r_ref;
                        n_dvs       = {8'd0, in_target} * {27'd0, C_FIXED_DIV};
                        n_div_start = 1'b1;
                        n_state     = S_W_TEMP;
                    end
                end
            end
            // temp = ref / (22 * target)
            S_W_TEMP: begin
                if (div_done) begin
                    n_temp = div_quo;
                    if (div_quo == 32'd0) begin
                        n_oor   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_dvs       = {13'd0, r_clamped} * {27'd0, C_FIXED_DIV};
                        n_div_start = 1'b1;
                        n_state     = S_W_REM;
                    end
                end
            end
            // remainder against the clamped target decides on temp + 1
            S_W_REM: begin
                if (div_done) begin
                    n_inc       = (div_rem != 32'd0);
                    n_second    = 1'b0;
                    n_t         = r_temp;
                    n_best_err  = {13'd0, r_clamped};
                    n_best_a    = 2'd0;
                    n_best_b    = 6'd0;
                    n_last_err  = {13'd0, r_clamped};
                    n_cand_a    = 2'd0;
                    n_cand_b    = 6'd0;
                    n_b         = 6'd0;
                    n_dvd       = r_temp;
                    n_dvs       = 32'd1;
                    n_div_start = 1'b1;
                    n_state     = S_W_Q;
                end
            end
            // first-stage divisor for this b
            S_W_Q: begin
                if (div_done) begin
                    if (q_adj > C_A_MAX) begin
                        n_state = S_NEXT_B;
                    end else begin
                        n_a         = q_adj[1:0];
                        n_dvd       = r_ref;
                        n_dvs       = {19'd0, act_div};
                        n_div_start = 1'b1;
                        n_state     = S_W_ACT;
                    end
                end
            end
            // actual clock and its error
            S_W_ACT: begin
                if (div_done) begin
                    if (r_last_err > act_err) begin
                        n_last_err = act_err;
                        n_cand_a   = r_a;
                        n_cand_b   = r_b;
                    end
                    n_state = S_NEXT_B;
                end
            end
            // step b, or close this t
            S_NEXT_B: begin
                if (r_b == C_B_LAST) begin
                    if (r_last_err < r_best_err) begin
                        n_best_err = r_last_err;
                        n_best_a   = r_cand_a;
                        n_best_b   = r_cand_b;
                    end
                    if (r_inc && !r_second) begin
                        n_second    = 1'b1;
                        n_t         = r_t + 32'd1;
                        n_last_err  = {13'd0, r_clamped};
                        n_cand_a    = 2'd0;
                        n_cand_b    = 6'd0;
                        n_b         = 6'd0;
                        n_dvd       = r_t + 32'd1;
                        n_dvs       = 32'd1;
                        n_div_start = 1'b1;
                        n_state     = S_W_Q;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_b         = r_b + 6'd1;
                    n_dvd       = r_t;
                    n_dvs       = {25'd0, 7'({1'b0, r_b} + 7'd2)};
                    n_div_start = 1'b1;
                    n_state     = S_W_Q;
                end
            end
            // hand the item to the output register
            S_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_oor;
                    if (r_oor) begin
                        n_m_data = {r_ctrl, r_ctrl[13:8], r_ctrl[15:14]};
                    end else begin
                        n_m_data = {ctrl_new, r_best_b, r_best_a};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref       <= C_REF_RESET;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref       <= n_ref;
            r_div_start <= n_div_start;
            r_m_valid   <= n_m_valid;
        end
        r_ctrl     <= n_ctrl;
        r_clamped  <= n_clamped;
        r_temp     <= n_temp;
        r_t        <= n_t;
        r_inc      <= n_inc;
        r_second   <= n_second;
        r_b        <= n_b;
        r_a        <= n_a;
        r_last_err <= n_last_err;
        r_cand_a   <= n_cand_a;
        r_cand_b   <= n_cand_b;
        r_best_err <= n_best_err;
        r_best_a   <= n_best_a;
        r_best_b   <= n_best_b;
        r_oor      <= n_oor;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_m_data   <= n_m_data;
        r_m_user   <= n_m_user;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // divisor fields always agree with the control word they went into
    a_fields_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == o_m_tdata[23:22]) &&
                       (o_m_tdata[7:2] == o_m_tdata[21:16]))
        else $error("divisor fields differ from control word");

    // the divider only reports back while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_W_TEMP) || (r_state == S_W_REM) ||
                     (r_state == S_W_Q) || (r_state == S_W_ACT))
        else $error("divider result outside a wait state");

    // no new item while a division is still running
    a_idle_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !div_busy && !r_div_start)
        else $error("input ready while divider busy");

endmodule

### tb/testbench.sv
// self-checking testbench for the i2c clock divisor search unit
`timescale 1ns / 1ps

module testbench
    import i2cds_pkg::*;
();

    typedef struct packed {
        logic [23:0] target_hz;
        logic [31:0] control_in;
    } t_divisor_request;

    typedef struct packed {
        logic [1:0]  div_a;
        logic [5:0]  div_b;
        logic [31:0] control_out;
        logic        out_of_range;
    } t_divisor_result;

    // ports of the unit
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [39:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    // shared testbench state
    t_divisor_request pending_requests[$];
    t_divisor_result  expected_results[$];
    t_divisor_request send_req;
    logic [31:0]      ref_clock_model   = C_REF_RESET;
    logic             steady_flow       = 1'b0;
    logic             in_fire           = 1'b0;
    int               send_gap          = 0;
    int               ready_hold        = 0;
    int               submitted_count   = 0;
    int               accepted_count    = 0;
    int               result_count      = 0;
    int               out_of_range_count = 0;
    int               mismatch_count    = 0;
    int               setting_count     = 1;

    i2c_clock_divisor_search_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // target_hz[23:0], control_in[55:24]
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // div_a[1:0], div_b[7:2], control_out[39:8]
        .o_m_tuser   (o_m_tuser)    // out_of_range[0]
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // divisor search predictor
    function automatic t_divisor_result predict_divisor(input t_divisor_request req,
                                                        input logic [31:0] ref_hz);
        logic [63:0]     ref_w, fixed_w, base_q, last_q, t, q, b_plus, actual;
        logic [31:0]     clamped, best_err, run_err, err;
        logic [1:0]      best_a, run_a;
        logic [5:0]      best_b, run_b;
        int              b;
        t_divisor_result res;
        ref_w   = {32'd0, ref_hz};
        fixed_w = {59'd0, C_FIXED_DIV};
        base_q  = (req.target_hz == '0) ? 64'd0 : ref_w / (fixed_w * {40'd0, req.target_hz});
        // zero target or a target beyond the reference: control word passes through
        if (base_q == 64'd0) begin
            res.div_a        = req.control_in[15:14];
            res.div_b        = req.control_in[13:8];
            res.control_out  = req.control_in;
            res.out_of_range = 1'b1;
            return res;
        end
        // clamp the target into the supported bus speeds
        clamped = {8'd0, req.target_hz};
        if (clamped > {8'd0, C_CLAMP_HIGH})
            clamped = {8'd0, C_CLAMP_HIGH};
        if (clamped <= {8'd0, C_CLAMP_MID_HI} && clamped > {8'd0, C_CLAMP_MID_LO})
            clamped = {8'd0, C_CLAMP_MID_LO};
        last_q   = (ref_w % (fixed_w * {32'd0, clamped}) != 64'd0) ? base_q + 64'd1 : base_q;
        best_err = clamped;
        best_a   = '0;
        best_b   = '0;
        // walk the one or two quotient candidates and every second-stage divisor
        for (t = base_q; t <= last_q; t++) begin
            run_err = clamped;
            run_a   = '0;
            run_b   = '0;
            for (b = 0; b <= int'(C_B_LAST); b++) begin
                b_plus = 64'(b + 1);
                q      = t / b_plus;
                if (q != 64'd0)
                    q = q - 64'd1;
                if (q <= {32'd0, C_A_MAX}) begin
                    actual = ref_w / (fixed_w * (q + 64'd1) * b_plus);
                    err    = (actual[31:0] > clamped) ? actual[31:0] - clamped
                                                      : clamped - actual[31:0];
                    if (run_err > err) begin
                        run_err = err;
                        run_a   = q[1:0];
                        run_b   = b[5:0];
                    end
                end
            end
            if (run_err < best_err) begin
                best_err = run_err;
                best_a   = run_a;
                best_b   = run_b;
            end
        end
        res.div_a        = best_a;
        res.div_b        = best_b;
        res.control_out  = (req.control_in & ~(C_MASK_A | C_MASK_B)) |
                           {16'd0, best_a, best_b, 8'd0};
        res.out_of_range = 1'b0;
        return res;
    endfunction

    // idle length: none in steady flow, else mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 150);
    endfunction

    // input driver, fed from the pending request queue
    always @(negedge i_clk) begin
        if (!i_s_tvalid || in_fire) begin
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   = send_gap - 1;
            end else if (pending_requests.size() != 0) begin
                send_req   = pending_requests.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {send_req.control_in, send_req.target_hz};
                send_gap   = idle_length();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 5) == 0)
                ready_hold = idle_length();
        end
    end

    // monitor: predict on accepted input items, check accepted result items
    always @(posedge i_clk) begin
        t_divisor_result  got, want;
        t_divisor_request seen_req;
        in_fire <= i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            seen_req.target_hz  = i_s_tdata[23:0];
            seen_req.control_in = i_s_tdata[55:24];
            expected_results.push_back(predict_divisor(seen_req, ref_clock_model));
            accepted_count++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.div_a        = o_m_tdata[1:0];
            got.div_b        = o_m_tdata[7:2];
            got.control_out  = o_m_tdata[39:8];
            got.out_of_range = o_m_tuser[0];
            result_count++;
            if (got.out_of_range === 1'b1)
                out_of_range_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item %0d: a=%0d b=%0d ctrl=%08h oor=%0d",
                             result_count, got.div_a, got.div_b,
                             got.control_out, got.out_of_range);
            end else begin
                want = expected_results.pop_front();
                if (got.div_a !== want.div_a || got.div_b !== want.div_b ||
                    got.control_out !== want.control_out ||
                    got.out_of_range !== want.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result item %0d: want a=%0d b=%0d ctrl=%08h oor=%0d,",
                                  " got a=%0d b=%0d ctrl=%08h oor=%0d"},
                                 result_count, want.div_a, want.div_b,
                                 want.control_out, want.out_of_range, got.div_a,
                                 got.div_b, got.control_out, got.out_of_range);
                end
            end
        end
    end

    task automatic queue_request(input logic [23:0] target, input logic [31:0] ctrl);
        t_divisor_request req;
        req.target_hz  = target;
        req.control_in = ctrl;
        pending_requests.push_back(req);
        submitted_count++;
    endtask

    // random requests weighted toward the interesting target ranges
    task automatic queue_random(input int count);
        int          r;
        logic [23:0] target;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                target = '0;
            else if (r < 17)
                target = 24'($urandom_range(89990, 100010));
            else if (r < 27)
                target = 24'($urandom_range(384590, 600000));
            else if (r < 37)
                target = 24'($urandom);
            else if (r < 47)
                target = 24'($urandom_range(1, 2000));
            else
                target = 24'($urandom_range(10000, 400000));
            queue_request(target, $urandom);
        end
    endtask

    // wait until every submitted item has been accepted and answered
    task automatic wait_drained();
        while (accepted_count != submitted_count || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // reference clock write, only while the unit is idle
    task automatic write_ref_clock(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ref_clock_model = value;
        setting_count++;
    endtask

    // stimulus
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // reset reference: zero target, overflow, clamp edges, temp of one
        queue_request(24'd0, 32'h0000_0000);
        queue_request(24'd0, 32'hFFFF_FFFF);
        queue_request(24'hFF_FFFF, 32'hA5A5_A5A5);
        queue_request(24'd5050505, 32'hFFFF_FFFF);
        queue_request(24'd5050506, 32'h5A5A_5A5A);
        queue_request(24'd1, 32'hFFFF_FFFF);
        queue_request(24'd384600, 32'h0000_0000);
        queue_request(24'd384601, $urandom);
        queue_request(24'd400000, $urandom);
        queue_request(24'd100000, 32'hFFFF_FFFF);
        queue_request(24'd100001, $urandom);
        queue_request(24'd90000, $urandom);
        queue_request(24'd90001, 32'h0000_0000);
        queue_request(24'd89999, $urandom);
        queue_request(24'd95000, $urandom);
        queue_request(24'd100, $urandom);
        queue_request(24'd20000, $urandom);
        queue_request(24'd50000, $urandom);
        queue_request(24'd200000, $urandom);
        queue_request(24'd300000, $urandom);
        queue_random(10);
        wait_drained();

        // reference that divides some targets exactly
        steady_flow = 1'b1;
        write_ref_clock(32'd88000000);
        queue_request(24'd50000, $urandom);
        queue_request(24'd40000, $urandom);
        queue_request(24'd100000, $urandom);
        queue_request(24'd400000, $urandom);
        queue_random(25);
        wait_drained();

        // largest reference
        steady_flow = 1'b0;
        write_ref_clock(32'hFFFF_FFFF);
        queue_random(25);
        wait_drained();

        // smallest reference: nothing can be divided
        write_ref_clock(32'd1);
        queue_random(10);
        wait_drained();

        // arbitrary reference
        write_ref_clock($urandom);
        queue_random(20);
        wait_drained();

        // back to the reset value without idling
        steady_flow = 1'b1;
        write_ref_clock(C_REF_RESET);
        queue_random(20);
        wait_drained();

        repeat (200) @(negedge i_clk);
        mismatch_count += expected_results.size();
        $display("checked %0d result items from %0d requests, %0d of them out of range,",
                 result_count, submitted_count, out_of_range_count);
        $display("across %0d reference clock settings", setting_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial begin
        #(12 * 6000000);
        $display("Mismatches found");
        $finish;
    end

endmodule
